// File: design/dtq_pkg.sv
package dtq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 48;
  localparam int MAX_OUT   = 16;

  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  localparam int FUNC_W    = 2;
  localparam int DELAY_W   = 32;
  localparam int ID_SLOT_W = 4;
  localparam int TAG_W     = 8;
  localparam int KIND_W    = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [TAG_W-1:0]     tag_t;

  // request functions
  localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd3;

  // response kinds
  localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STALE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEARED   = 3'd5;

  // cell commands
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_REMOVE = 2'd2;
  localparam logic [1:0] CELL_CLEAR  = 2'd3;

  // what one cell shows its neighbours
  typedef struct packed {
    logic  valid;
    logic  keep;     // holds its entry on an insert
    logic  hit;      // this cell or one to its left is removed
    time_t deadline;
    slot_t slot;
  } cell_link_t;

  // command broadcast to every cell
  typedef struct packed {
    logic [1:0] cmd;
    time_t      deadline;
    slot_t      slot;
    slot_t      key;
  } cell_op_t;

  typedef struct packed {
    logic  claim;
    logic  free;
    logic  clear_all;
    slot_t addr;
  } slot_ctrl_t;

endpackage

// File: design/dtq_if.sv
interface dtq_req_if;
  logic                          valid;
  logic                          ready;
  logic [dtq_pkg::FUNC_W-1:0]    func;
  logic [dtq_pkg::DELAY_W-1:0]   delay;
  logic [dtq_pkg::ID_SLOT_W-1:0] event_slot;
  logic [dtq_pkg::TAG_W-1:0]     event_tag;

  modport source (output valid, func, delay, event_slot, event_tag, input ready);
  modport sink   (input valid, func, delay, event_slot, event_tag, output ready);
endinterface

interface dtq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dtq_pkg::KIND_W-1:0]    kind;
  logic [dtq_pkg::ID_SLOT_W-1:0] out_slot;
  logic [dtq_pkg::TAG_W-1:0]     out_tag;
  logic                          last;

  modport source (output valid, kind, out_slot, out_tag, last, input ready);
  modport sink   (input valid, kind, out_slot, out_tag, last, output ready);
endinterface

// File: design/dtq_cell.sv
module dtq_cell (
  input  logic                clk,
  input  logic                rst,
  input  dtq_pkg::cell_op_t   op,
  input  dtq_pkg::cell_link_t left,
  input  dtq_pkg::cell_link_t right,
  output dtq_pkg::cell_link_t link
);
  import dtq_pkg::*;

  logic  valid;
  time_t deadline;
  slot_t slot;
  logic  valid_next;
  time_t deadline_next;
  slot_t slot_next;
  logic  keep;
  logic  hit;

  assign keep = valid && (deadline <= op.deadline);
  assign hit  = left.hit || (valid && (op.cmd == CELL_REMOVE) && (slot == op.key));

  always_comb begin
    valid_next    = valid;
    deadline_next = deadline;
    slot_next     = slot;
    case (op.cmd)
      CELL_INSERT: begin
        valid_next = valid || left.valid;
        if (!keep) begin
          if (left.keep) begin
            deadline_next = op.deadline;
            slot_next     = op.slot;
          end else begin
            deadline_next = left.deadline;
            slot_next     = left.slot;
          end
        end
      end
      CELL_REMOVE: begin
        // close the gap: take the right neighbour's entry
        if (hit) begin
          valid_next    = right.valid;
          deadline_next = right.deadline;
          slot_next     = right.slot;
        end
      end
      CELL_CLEAR: valid_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= deadline_next;
    slot     <= slot_next;
  end

  assign link.valid    = valid;
  assign link.keep     = keep;
  assign link.hit      = hit;
  assign link.deadline = deadline;
  assign link.slot     = slot;

endmodule

// File: design/dtq_slots.sv
module dtq_slots (
  input  logic                clk,
  input  logic                rst,
  input  dtq_pkg::slot_ctrl_t ctrl,
  input  dtq_pkg::slot_t      rd_addr,
  output dtq_pkg::tag_t       rd_tag,
  output logic                rd_busy,
  output logic                free_found,
  output dtq_pkg::slot_t      free_slot
);
  import dtq_pkg::*;

  logic [DEPTH-1:0] busy;
  tag_t             tag [DEPTH];

  assign rd_tag  = tag[rd_addr];
  assign rd_busy = busy[rd_addr];

  // lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        tag[i] <= '0;
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if ((ctrl.clear_all && busy[i]) || (ctrl.free && (ctrl.addr == SLOT_W'(i)))) begin
          // drop the slot and age its tag so old ids go stale
          busy[i] <= 1'b0;
          tag[i]  <= tag[i] + 1'b1;
        end else if (ctrl.claim && (ctrl.addr == SLOT_W'(i))) begin
          busy[i] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/deadline_timer_queue.sv
// Deadline-ordered timer event queue.
// Requests arrive on req (valid/ready): func selects schedule, cancel, tick or
// cancel-all. Responses leave on rsp (valid/ready), one transfer per result,
// with last set on the final result of each request.
// Pending events sit in a row of cells kept sorted by deadline, earliest at
// cell 0; equal deadlines keep arrival order. A schedule inserts with every
// cell comparing against the new deadline in parallel; a cancel or a pop
// removes one entry by shifting the cells to its right one place left.
// Schedule, cancel and cancel-all each give a single result, loaded into the
// output register from the execute state that follows the request transfer.
// A tick first advances time, then pops the fired events one at a time from
// the head of the cell row, each when the output register is free; a tick
// that fires nothing returns no result.
// A new request is taken only once the previous one has finished.
// Reset empties the queue, frees all slots, zeroes all tags and time.
// When the receiver stalls, the result is held in the output register and
// the queue waits with it; nothing is lost or repeated.
module deadline_timer_queue (
  input logic       clk,
  input logic       rst,
  dtq_req_if.sink   req,
  dtq_rsp_if.source rsp
);
  import dtq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIRE = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [FUNC_W-1:0]    cmd_func;
  logic [DELAY_W-1:0]   cmd_delay;
  logic [ID_SLOT_W-1:0] cmd_slot;
  tag_t                 cmd_tag;
  time_t                time_now;
  time_t                time_next;
  logic [CNT_W-1:0]     fire_cnt;
  logic [CNT_W-1:0]     fire_cnt_next;

  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [ID_SLOT_W-1:0] out_slot;
  tag_t                 out_tag;
  logic                 out_last;

  logic                 load;
  logic [KIND_W-1:0]    kind_next;
  logic [ID_SLOT_W-1:0] slot_next;
  tag_t                 tag_next;
  logic                 last_next;

  cell_op_t             op;
  logic                 pop;
  cell_link_t           links [DEPTH];
  cell_link_t           head_bound;
  cell_link_t           tail_bound;

  slot_ctrl_t           sctl;
  slot_t                rd_addr;
  tag_t                 rd_tag;
  logic                 rd_busy;
  logic                 free_found;
  slot_t                free_slot;

  logic                 accept;
  logic                 out_free;
  logic [TIME_BITS:0]   sum;
  time_t                new_deadline;
  slot_t                key_slot;
  logic                 in_range;
  logic                 cancel_ok;
  logic                 queue_full;
  logic                 fire_more;
  logic                 next_more;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free = !out_valid || rsp.ready;

  // saturate the deadline at the top of the time range
  assign sum          = {1'b0, time_now} + (TIME_BITS + 1)'(cmd_delay);
  assign new_deadline = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign key_slot   = SLOT_W'(cmd_slot);
  assign in_range   = 32'(cmd_slot) < DEPTH;
  assign cancel_ok  = in_range && rd_busy && (rd_tag == cmd_tag);
  assign queue_full = !free_found || links[DEPTH-1].valid;

  // head expiry, and whether the entry behind it will follow in this burst
  assign fire_more = links[0].valid && (links[0].deadline <= time_now) &&
                     (fire_cnt < CNT_W'(MAX_OUT));
  assign next_more = links[1].valid && (links[1].deadline <= time_now) &&
                     (({1'b0, fire_cnt} + 1'b1) < (CNT_W + 1)'(MAX_OUT));

  always_comb begin
    if (state == ST_FIRE) begin
      rd_addr = links[0].slot;
    end else if (cmd_func == FUNC_SCHEDULE) begin
      rd_addr = free_slot;
    end else begin
      rd_addr = key_slot;
    end
  end

  // boundary cells: an always-kept, valid entry before the head, empty after the tail
  always_comb begin
    head_bound       = '0;
    head_bound.valid = 1'b1;
    head_bound.keep  = 1'b1;
    head_bound.hit   = pop;
    tail_bound       = '0;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dtq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .left  ((i == 0) ? head_bound : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? tail_bound : links[(i == DEPTH - 1) ? i : i + 1]),
      .link  (links[i])
    );
  end

  dtq_slots u_slots (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sctl),
    .rd_addr    (rd_addr),
    .rd_tag     (rd_tag),
    .rd_busy    (rd_busy),
    .free_found (free_found),
    .free_slot  (free_slot)
  );

  always_comb begin
    state_next    = state;
    time_next     = time_now;
    fire_cnt_next = fire_cnt;
    op.cmd        = CELL_HOLD;
    op.deadline   = new_deadline;
    op.slot       = free_slot;
    op.key        = key_slot;
    pop           = 1'b0;
    sctl          = '0;
    sctl.addr     = rd_addr;
    load          = 1'b0;
    kind_next     = KIND_SCHEDULED;
    slot_next     = '0;
    tag_next      = '0;
    last_next     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_TICK) begin
            // advance time, saturating
            if (time_now != '1) begin
              time_next = time_now + 1'b1;
            end
            fire_cnt_next = '0;
            state_next    = ST_FIRE;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          unique case (cmd_func)
            FUNC_SCHEDULE: begin
              if (queue_full) begin
                kind_next = KIND_FULL;
              end else begin
                op.cmd     = CELL_INSERT;
                sctl.claim = 1'b1;
                kind_next  = KIND_SCHEDULED;
                slot_next  = ID_SLOT_W'(free_slot);
                tag_next   = rd_tag;
              end
            end
            FUNC_CANCEL: begin
              slot_next = cmd_slot;
              tag_next  = cmd_tag;
              if (cancel_ok) begin
                op.cmd    = CELL_REMOVE;
                sctl.free = 1'b1;
                kind_next = KIND_CANCELLED;
              end else begin
                kind_next = KIND_STALE;
              end
            end
            FUNC_CLEAR: begin
              op.cmd         = CELL_CLEAR;
              sctl.clear_all = 1'b1;
              kind_next      = KIND_CLEARED;
            end
            default: ;
          endcase
        end
      end
      ST_FIRE: begin
        if (!fire_more) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          // pop the head and free its slot
          load          = 1'b1;
          op.cmd        = CELL_REMOVE;
          pop           = 1'b1;
          sctl.free     = 1'b1;
          kind_next     = KIND_FIRED;
          slot_next     = ID_SLOT_W'(links[0].slot);
          tag_next      = rd_tag;
          last_next     = !next_more;
          fire_cnt_next = fire_cnt + 1'b1;
          if (!next_more) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      time_now  <= '0;
      fire_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      time_now <= time_next;
      fire_cnt <= fire_cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the request fields for the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func  <= req.func;
      cmd_delay <= req.delay;
      cmd_slot  <= req.event_slot;
      cmd_tag   <= req.event_tag;
    end
    if (load) begin
      out_kind <= kind_next;
      out_slot <= slot_next;
      out_tag  <= tag_next;
      out_last <= last_next;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.kind     = out_kind;
  assign rsp.out_slot = out_slot;
  assign rsp.out_tag  = out_tag;
  assign rsp.last     = out_last;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

import dtq_pkg::*;

// One result as it leaves the block.
typedef struct packed {
  logic [KIND_W-1:0]    kind;
  logic [ID_SLOT_W-1:0] slot;
  tag_t                 tag;
  logic                 last;
} timer_result_t;

// Event id as handed out by a schedule.
typedef struct packed {
  logic [ID_SLOT_W-1:0] slot;
  tag_t                 tag;
} timer_id_t;

// Mirror of the queue: time, deadline-ordered rows, slot ownership and tags.
// Every accepted request is replayed here and yields the results it should cause.
class timer_scoreboard;
  time_t         now_ticks;
  time_t         row_deadline [DEPTH];
  slot_t         row_slot     [DEPTH];
  int            row_count;
  bit            slot_taken   [DEPTH];
  tag_t          slot_gen     [DEPTH];
  timer_result_t awaited      [$];
  timer_id_t     issued_ids   [$];
  int            fails;

  function new();
    now_ticks = '0;
    row_count = 0;
    fails     = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_taken[i] = 1'b0;
      slot_gen[i]   = '0;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void await_result(logic [KIND_W-1:0] kind, logic [ID_SLOT_W-1:0] slot, tag_t tag);
    timer_result_t r;
    r.kind = kind;
    r.slot = slot;
    r.tag  = tag;
    r.last = 1'b0;
    awaited.push_back(r);
  endfunction

  function void retire_slot(int s);
    slot_taken[s] = 1'b0;
    slot_gen[s]   = slot_gen[s] + 1'b1;
  endfunction

  function void drop_row(int idx);
    for (int i = idx; i + 1 < row_count; i++) begin
      row_deadline[i] = row_deadline[i+1];
      row_slot[i]     = row_slot[i+1];
    end
    row_count--;
  endfunction

  // Replay one accepted request.
  function void note_request(logic [FUNC_W-1:0] func, logic [DELAY_W-1:0] delay,
                             logic [ID_SLOT_W-1:0] eslot, tag_t etag);
    int          prior_count;
    int          s;
    int          p;
    int          fired;
    logic [63:0] sum;
    time_t       due;
    bit          done;
    timer_id_t   id;
    prior_count = awaited.size();
    case (func)
      FUNC_SCHEDULE: begin
        s = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (!slot_taken[i]) begin
            s = i;
            break;
          end
        end
        if (s < 0 || row_count >= DEPTH) begin
          await_result(KIND_FULL, '0, '0);
        end else begin
          sum = 64'(now_ticks) + 64'(delay);
          if (sum[63:TIME_BITS] != '0) due = '1;
          else due = sum[TIME_BITS-1:0];
          // equal deadlines go behind the ones already queued
          p = 0;
          while (p < row_count && row_deadline[p] <= due) p++;
          for (int i = row_count; i > p; i--) begin
            row_deadline[i] = row_deadline[i-1];
            row_slot[i]     = row_slot[i-1];
          end
          row_deadline[p] = due;
          row_slot[p]     = slot_t'(s);
          row_count++;
          slot_taken[s] = 1'b1;
          await_result(KIND_SCHEDULED, ID_SLOT_W'(s), slot_gen[s]);
          id.slot = ID_SLOT_W'(s);
          id.tag  = slot_gen[s];
          issued_ids.push_back(id);
          if (issued_ids.size() > 24) void'(issued_ids.pop_front());
        end
      end
      FUNC_CANCEL: begin
        done = 1'b0;
        if (slot_taken[eslot] && slot_gen[eslot] == etag) begin
          for (int i = 0; i < row_count; i++) begin
            if (row_slot[i] == slot_t'(eslot)) begin
              drop_row(i);
              retire_slot(eslot);
              done = 1'b1;
              break;
            end
          end
        end
        await_result(done ? KIND_CANCELLED : KIND_STALE, eslot, etag);
      end
      FUNC_TICK: begin
        if (now_ticks != '1) now_ticks = now_ticks + 1'b1;
        fired = 0;
        while (fired < MAX_OUT && row_count > 0 && row_deadline[0] <= now_ticks) begin
          s = row_slot[0];
          await_result(KIND_FIRED, ID_SLOT_W'(s), slot_gen[s]);
          drop_row(0);
          retire_slot(s);
          fired++;
        end
      end
      default: begin
        for (int i = 0; i < row_count; i++) retire_slot(row_slot[i]);
        row_count = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_taken[i]) retire_slot(i);
        end
        await_result(KIND_CLEARED, '0, '0);
      end
    endcase
    if (awaited.size() > prior_count) awaited[awaited.size()-1].last = 1'b1;
  endfunction

  // Compare one result transfer with the oldest expectation.
  function void check_result(timer_result_t got);
    timer_result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result kind=%0d slot=%0d tag=%0d last=%0b",
               $time, got.kind, got.slot, got.tag, got.last);
      fails++;
      return;
    end
    want = awaited.pop_front();
    if (got !== want) begin
      $display("%0t: result mismatch expected kind=%0d slot=%0d tag=%0d last=%0b, actual kind=%0d slot=%0d tag=%0d last=%0b",
               $time, want.kind, want.slot, want.tag, want.last,
               got.kind, got.slot, got.tag, got.last);
      fails++;
    end
  endfunction

  // Pick a live event id at random; 0 when the queue is empty.
  function bit pick_live(output logic [ID_SLOT_W-1:0] slot, output tag_t tag);
    int live [$];
    int k;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_taken[i]) live.push_back(i);
    end
    if (live.size() == 0) return 1'b0;
    k    = live[$urandom_range(0, live.size() - 1)];
    slot = ID_SLOT_W'(k);
    tag  = slot_gen[k];
    return 1'b1;
  endfunction

  // Pick a recently issued id, which may have fired or been cancelled since.
  function bit pick_issued(output logic [ID_SLOT_W-1:0] slot, output tag_t tag);
    timer_id_t id;
    if (issued_ids.size() == 0) return 1'b0;
    id   = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    slot = id.slot;
    tag  = id.tag;
    return 1'b1;
  endfunction
endclass

module tb_top;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 60;
  localparam int NORMAL_ITEMS     = 200;
  localparam int HEAVY_ITEMS      = 100;
  localparam int CALM_ITEMS       = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtq_req_if req_ch ();
  dtq_rsp_if rsp_ch ();

  deadline_timer_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  timer_scoreboard sb = new();

  // calm: no idling on either side; hold_wanted: ask the receiver for one long hold-off
  bit calm        = 1'b0;
  bit hold_wanted = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fail the run if it hangs anywhere.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result receiver: random stall bursts, stretches of full throughput,
  // and one long hold-off counted here so the queue backs up into its input.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int stall_pct;
    int cyc;
    stall_left   = 0;
    hold_left    = 0;
    stall_pct    = 25;
    cyc          = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      // change the stall rate every so often so some stretches run flat out
      if (cyc % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (hold_wanted && hold_left == 0) begin
        hold_left   = LONG_HOLD_CYCLES;
        hold_wanted = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer as it happens.
  always @(posedge clk) begin
    timer_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.kind = rsp_ch.kind;
      got.slot = rsp_ch.out_slot;
      got.tag  = rsp_ch.out_tag;
      got.last = rsp_ch.last;
      sb.check_result(got);
    end
  end

  // Offer one request from the falling edge and hold it until the transfer.
  // Valid is left high so back-to-back requests never drop it.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [DELAY_W-1:0] delay,
                              input logic [ID_SLOT_W-1:0] eslot, input tag_t etag);
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.delay      <= delay;
    req_ch.event_slot <= eslot;
    req_ch.event_tag  <= etag;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(func, delay, eslot, etag);
  endtask

  // Drop valid for a number of whole cycles.
  task automatic idle_request(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  task automatic sender_jitter();
    if (!calm && $urandom_range(0, 3) == 0) idle_request($urandom_range(1, 6));
  endtask

  // Hold the sender until every expected result has been seen.
  task automatic drain_results();
    idle_request(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random request. heavy leans towards schedules so the queue fills up.
  task automatic random_request(input bit heavy);
    int                   r;
    int                   c;
    int                   sched_pct;
    logic [DELAY_W-1:0]   d;
    logic [ID_SLOT_W-1:0] s;
    tag_t                 t;
    sched_pct = heavy ? 65 : 35;
    r         = $urandom_range(0, 99);
    if (r < sched_pct) begin
      case ($urandom_range(0, 9))
        0:       d = $urandom;
        1:       d = $urandom_range(0, 2000);
        default: d = $urandom_range(0, 12);
      endcase
      // the id fields are noise here and must be ignored
      send_request(FUNC_SCHEDULE, d, ID_SLOT_W'($urandom), TAG_W'($urandom));
    end else if (r < sched_pct + 20) begin
      c = $urandom_range(0, 9);
      if (c < 6 && sb.pick_live(s, t)) begin
        send_request(FUNC_CANCEL, $urandom, s, t);
      end else if (c == 6 && sb.pick_live(s, t)) begin
        // right slot, wrong generation
        send_request(FUNC_CANCEL, $urandom, s, t ^ TAG_W'($urandom_range(1, 255)));
      end else if (c < 9 && sb.pick_issued(s, t)) begin
        send_request(FUNC_CANCEL, $urandom, s, t);
      end else begin
        send_request(FUNC_CANCEL, $urandom, ID_SLOT_W'($urandom), TAG_W'($urandom));
      end
    end else if (r < 97) begin
      send_request(FUNC_TICK, $urandom, ID_SLOT_W'($urandom), TAG_W'($urandom));
    end else begin
      send_request(FUNC_CLEAR, $urandom, ID_SLOT_W'($urandom), TAG_W'($urandom));
    end
  endtask

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_SCHEDULE;
    req_ch.delay      = '0;
    req_ch.event_slot = '0;
    req_ch.event_tag  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: quiet tick with every ignored field set high
    send_request(FUNC_TICK, '1, '1, '1);
    sender_jitter();
    // cancel of a slot that was never taken
    send_request(FUNC_CANCEL, '0, '0, '0);
    // far deadline, then a cancel with the wrong tag, a live cancel and a repeat of it
    send_request(FUNC_SCHEDULE, '1, '0, '0);
    send_request(FUNC_CANCEL, '0, '0, '1);
    sender_jitter();
    send_request(FUNC_CANCEL, '0, '0, '0);
    send_request(FUNC_CANCEL, '0, '0, '0);
    // top slot, top tag, nothing there
    send_request(FUNC_CANCEL, '0, '1, '1);
    // Fill every slot with deadlines now and now+1 interleaved; the sort must
    // put all of the earlier ones first, each group in arrival order.
    for (int i = 0; i < DEPTH; i++) begin
      send_request(FUNC_SCHEDULE, (i % 2 == 0) ? DELAY_W'(1) : '0, '0, '0);
      sender_jitter();
    end
    // one too many
    send_request(FUNC_SCHEDULE, '0, '0, '0);
    // a single tick fires the full burst
    send_request(FUNC_TICK, '0, '0, '0);
    send_request(FUNC_SCHEDULE, '1, '0, '0);
    send_request(FUNC_CLEAR, '0, '0, '0);
    drain_results();

    // Random: ordinary mix
    for (int i = 0; i < NORMAL_ITEMS; i++) begin
      random_request(1'b0);
      sender_jitter();
    end
    // let everything come out before the next phase
    drain_results();

    // Random: schedule-heavy, with the receiver holding off for a long stretch
    for (int i = 0; i < HEAVY_ITEMS; i++) begin
      if (i == 10) hold_wanted = 1'b1;
      random_request(1'b1);
      sender_jitter();
    end

    // Random: no idling on either side
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) random_request(1'b0);

    drain_results();
    // allow any stray result to show itself
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
